// ===== rtl/iak_pkg.sv =====
// Package for the iambic keyer: constants, codes and item types.
`default_nettype none
package iak_pkg;

  // Width of the tick time base, which advances once per accepted item
  localparam int TIME_W = 32;

  localparam int DOT_W    = 12;
  localparam int DASH_W   = 14;
  localparam int PTT_W    = 10;
  localparam int TWITCH_W = 12;
  localparam int GAP_W    = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [GAP_W-1:0]  TWITCH_MAX    = GAP_W'(10000);
  localparam logic [GAP_W-1:0]  IDLE_TWITCHES = GAP_W'(100);
  localparam logic [TIME_W-1:0] NEXT_TR_RESET = TIME_W'(100);

  localparam logic [DOT_W-1:0]    DOT_RESET    = DOT_W'(100);
  localparam logic [DASH_W-1:0]   DASH_RESET   = DASH_W'(300);
  localparam logic [PTT_W-1:0]    PTT_RESET    = PTT_W'(0);
  localparam logic [TWITCH_W-1:0] TWITCH_RESET = TWITCH_W'(10);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOT    = 2'd0,
    CFG_DASH   = 2'd1,
    CFG_PTT    = 2'd2,
    CFG_TWITCH = 2'd3
  } cfg_index_t;

  // Keyer phases
  typedef enum logic [1:0] {
    PH_DIT     = 2'd0,
    PH_DAH     = 2'd1,
    PH_UP      = 2'd2,
    PH_UP_LONG = 2'd3
  } keyer_phase_t;

  // Element start codes
  localparam logic [1:0] START_NONE = 2'd0;
  localparam logic [1:0] START_DIT  = 2'd1;
  localparam logic [1:0] START_DAH  = 2'd2;

  typedef struct packed {
    logic dit_pressed;
    logic dah_pressed;
    logic paddle_enabled;
  } in_item_t;

  typedef struct packed {
    logic             key_level;
    logic [1:0]       element_start;
    logic             report_valid;
    logic [GAP_W-1:0] gap_count;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/iambic_a_keyer.sv =====
// Iambic mode A keyer: one tick item in, one result item out.
// The result of an item is registered and is valid in the cycle after the item is accepted.
// Throughput: one item per cycle; the input is ready whenever the output register
//   is empty or is being emptied in the same cycle.
// Reset (rst, synchronous): time base and latches cleared, phase long key up,
//   next transition at tick 100, registers back to their default lengths.
`default_nettype none
module iambic_a_keyer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire iak_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output iak_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [iak_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [iak_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int TW = iak_pkg::TIME_W;

  // Configuration registers
  logic [iak_pkg::DOT_W-1:0]    dot_ticks;
  logic [iak_pkg::DASH_W-1:0]   dash_ticks;
  logic [iak_pkg::PTT_W-1:0]    ptt_delay_ticks;
  logic [iak_pkg::TWITCH_W-1:0] twitch_ticks;

  // Keyer state
  logic [TW-1:0]              time_now;
  logic [TW-1:0]              next_transition, next_transition_next;
  logic [TW-1:0]              read_open_time, read_open_time_next;
  logic [TW-1:0]              twitch_deadline, twitch_deadline_next;
  iak_pkg::keyer_phase_t      keyer_phase, keyer_phase_next;
  iak_pkg::keyer_phase_t      previous_phase, previous_phase_next;
  logic                       dit_latched, dit_latched_next;
  logic                       dah_latched, dah_latched_next;
  logic [iak_pkg::GAP_W-1:0]  twitch_total, twitch_total_next;

  iak_pkg::out_item_t         result;
  logic                       accept;

  // Intermediate values
  logic                       read_open;
  logic                       dit_l, dah_l;
  logic                       twitch_hit;
  logic [iak_pkg::GAP_W-1:0]  twitch_inc;
  logic                       fire;
  logic                       starts;
  logic                       start_dit;
  logic [iak_pkg::DASH_W-1:0] elem_len;
  logic [15:0]                len_ptt;
  logic [15:0]                len_ptt_q;
  logic [1:0]                 start_code;
  logic                       rep;
  logic [iak_pkg::GAP_W-1:0]  gap;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Paddle latching and twitch counting, ahead of the phase decision
  always_comb begin
    read_open  = (time_now >= read_open_time);
    dit_l      = dit_latched || (read_open && in_data.dit_pressed);
    dah_l      = dah_latched || (read_open && in_data.dah_pressed);
    twitch_hit = (twitch_deadline <= time_now);
    twitch_inc = twitch_total;
    if (twitch_hit && (twitch_total < iak_pkg::TWITCH_MAX)) begin
      twitch_inc = twitch_total + 1'b1;
    end
    fire = in_data.paddle_enabled && (time_now >= next_transition);
  end

  // Next phase and timer updates
  always_comb begin
    keyer_phase_next     = keyer_phase;
    previous_phase_next  = previous_phase;
    next_transition_next = next_transition;
    read_open_time_next  = read_open_time;
    dit_latched_next     = dit_l;
    dah_latched_next     = dah_l;
    twitch_total_next    = twitch_inc;
    twitch_deadline_next = twitch_hit ? (time_now + TW'(twitch_ticks)) : twitch_deadline;
    if (fire) begin
      case (keyer_phase)
        iak_pkg::PH_DIT, iak_pkg::PH_DAH: keyer_phase_next = iak_pkg::PH_UP;
        default: begin
          if (previous_phase == iak_pkg::PH_DIT) begin
            if (dah_l) keyer_phase_next = iak_pkg::PH_DAH;
            else if (dit_l) keyer_phase_next = iak_pkg::PH_DIT;
          end else begin
            if (dit_l) keyer_phase_next = iak_pkg::PH_DIT;
            else if (dah_l) keyer_phase_next = iak_pkg::PH_DAH;
          end
        end
      endcase
      previous_phase_next = keyer_phase;
      if (starts) begin
        next_transition_next = time_now + TW'(len_ptt);
        read_open_time_next  = time_now + TW'(len_ptt_q);
        dit_latched_next     = 1'b0;
        dah_latched_next     = 1'b0;
      end else if (keyer_phase_next == iak_pkg::PH_UP) begin
        if (keyer_phase == iak_pkg::PH_UP) begin
          // Idle gap: report and go to long key up
          if (twitch_inc >= iak_pkg::IDLE_TWITCHES) begin
            twitch_total_next = '0;
            keyer_phase_next  = iak_pkg::PH_UP_LONG;
          end
        end else begin
          // End of an element: one-dot gap
          twitch_total_next    = '0;
          next_transition_next = time_now + TW'(dot_ticks);
        end
      end
    end
  end

  // Element length and start detection
  always_comb begin
    starts    = fire && (keyer_phase != iak_pkg::PH_DIT) && (keyer_phase != iak_pkg::PH_DAH)
                && (dit_l || dah_l);
    // after a dit a latched dah wins, otherwise a latched dit wins
    start_dit = (previous_phase == iak_pkg::PH_DIT) ? !dah_l : dit_l;
    elem_len  = start_dit ? iak_pkg::DASH_W'(dot_ticks) : dash_ticks;
    len_ptt   = 16'(elem_len) + 16'(ptt_delay_ticks);
    len_ptt_q = len_ptt + 16'(dot_ticks[iak_pkg::DOT_W-1:2]);
  end

  // Result item
  always_comb begin
    start_code = iak_pkg::START_NONE;
    rep        = 1'b0;
    gap        = '0;
    if (starts) begin
      rep        = 1'b1;
      gap        = twitch_inc;
      start_code = (keyer_phase_next == iak_pkg::PH_DIT) ? iak_pkg::START_DIT
                                                         : iak_pkg::START_DAH;
    end else if (fire && (keyer_phase == iak_pkg::PH_UP)
                 && (twitch_inc >= iak_pkg::IDLE_TWITCHES)) begin
      rep = 1'b1;
      gap = twitch_inc;
    end
    result.key_level     = (keyer_phase_next == iak_pkg::PH_DIT) ||
                           (keyer_phase_next == iak_pkg::PH_DAH);
    result.element_start = start_code;
    result.report_valid  = rep;
    result.gap_count     = gap;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ticks       <= iak_pkg::DOT_RESET;
      dash_ticks      <= iak_pkg::DASH_RESET;
      ptt_delay_ticks <= iak_pkg::PTT_RESET;
      twitch_ticks    <= iak_pkg::TWITCH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        iak_pkg::CFG_DOT:    dot_ticks       <= cfg_data[iak_pkg::DOT_W-1:0];
        iak_pkg::CFG_DASH:   dash_ticks      <= cfg_data[iak_pkg::DASH_W-1:0];
        iak_pkg::CFG_PTT:    ptt_delay_ticks <= cfg_data[iak_pkg::PTT_W-1:0];
        iak_pkg::CFG_TWITCH: twitch_ticks    <= cfg_data[iak_pkg::TWITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Keyer state, advanced once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now        <= '0;
      next_transition <= iak_pkg::NEXT_TR_RESET;
      read_open_time  <= '0;
      twitch_deadline <= '0;
      keyer_phase     <= iak_pkg::PH_UP_LONG;
      previous_phase  <= iak_pkg::PH_UP_LONG;
      dit_latched     <= 1'b0;
      dah_latched     <= 1'b0;
      twitch_total    <= '0;
    end else if (accept) begin
      time_now        <= time_now + 1'b1;
      next_transition <= next_transition_next;
      read_open_time  <= read_open_time_next;
      twitch_deadline <= twitch_deadline_next;
      keyer_phase     <= keyer_phase_next;
      previous_phase  <= previous_phase_next;
      dit_latched     <= dit_latched_next;
      dah_latched     <= dah_latched_next;
      twitch_total    <= twitch_total_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire
